// File: rtl/core/bds_pkg.sv
// shared constants, types and codes for the bounded deque search block
package bds_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 64;
    localparam int OP_W  = 2;
    localparam int POS_W = 7;
    localparam int CNTO_W = 7;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_APPEND       = 2'd0;
    localparam t_op OP_PREPEND      = 2'd1;
    localparam t_op OP_SEARCH_FRONT = 2'd2;
    localparam t_op OP_SEARCH_BACK  = 2'd3;

    typedef logic [1:0] t_cell_mode;
    localparam t_cell_mode CELL_HOLD       = 2'd0;
    localparam t_cell_mode CELL_TAKE_RIGHT = 2'd1;
    localparam t_cell_mode CELL_TAKE_LEFT  = 2'd2;
    localparam t_cell_mode CELL_LOAD       = 2'd3;

    typedef logic [1:0] t_chain_op;
    localparam t_chain_op CH_HOLD    = 2'd0;
    localparam t_chain_op CH_ROTATE  = 2'd1;
    localparam t_chain_op CH_PREPEND = 2'd2;
    localparam t_chain_op CH_APPEND  = 2'd3;

    typedef struct packed {
        t_chain_op        op;
        logic [IDX_W-1:0] load_idx;
    } t_chain_ctl;

endpackage

// File: rtl/core/bds_cell.sv
// one storage cell of the deque chain
module bds_cell
    import bds_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_mode              i_mode,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    input  logic signed [VAL_W-1:0] i_load,
    output logic signed [VAL_W-1:0] o_value
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    always_comb begin
        case (i_mode)
            CELL_HOLD:       n_value = r_value;
            CELL_TAKE_RIGHT: n_value = i_right;
            CELL_TAKE_LEFT:  n_value = i_left;
            CELL_LOAD:       n_value = i_load;
            default:         n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: rtl/core/bds_chain.sv
// row of deque cells, front at cell zero, rotating toward the head for a scan
module bds_chain
    import bds_pkg::*;
(
    input  logic                    i_clk,
    input  t_chain_ctl              i_ctl,
    input  logic signed [VAL_W-1:0] i_value,
    output logic signed [VAL_W-1:0] o_head
);

    logic signed [VAL_W-1:0] w_val [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_mode              w_mode;
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_val[0];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        always_comb begin
            case (i_ctl.op)
                CH_HOLD:    w_mode = CELL_HOLD;
                CH_ROTATE:  w_mode = CELL_TAKE_RIGHT;
                CH_PREPEND: w_mode = CELL_TAKE_LEFT;
                CH_APPEND:  w_mode = (IDX_W'(g) == i_ctl.load_idx) ? CELL_LOAD : CELL_HOLD;
                default:    w_mode = CELL_HOLD;
            endcase
        end

        bds_cell u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode),
            .i_left  (w_left),
            .i_right (w_right),
            .i_load  (i_value),
            .o_value (w_val[g])
        );
    end

    assign o_head = w_val[0];

endmodule

// File: rtl/core/bounded_deque_search_top.sv
// top level of the bounded deque with front and back search
//
// channel | direction | handshake                   | word
// in      | input     | i_in_valid / o_in_stall     | i_operation, i_value
// out     | output    | o_out_valid / i_out_stall   | o_status, o_found_position,
//         |           |                             | o_empty, o_count
//
// a push places its result in the output register
// a search rotates the whole chain once past the head comparator
// reset clears count and control; cell contents need no reset
// the input stalls while a search runs or while an unread result blocks the output
module bounded_deque_search_top
    import bds_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [VAL_W-1:0]  i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_status,
    output logic signed [POS_W-1:0]  o_found_position,
    output logic                     o_empty,
    output logic [CNTO_W-1:0]        o_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic signed [POS_W-1:0] NOT_FOUND = '1;

    logic [1:0]              r_state,   n_state;
    logic [CNT_W-1:0]        r_count,   n_count;
    logic [IDX_W-1:0]        r_step,    n_step;
    logic signed [VAL_W-1:0] r_key,     n_key;
    logic                    r_back,    n_back;
    logic                    r_hit,     n_hit;
    logic [IDX_W-1:0]        r_hit_k,   n_hit_k;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_status, n_out_status;
    logic signed [POS_W-1:0] r_out_pos, n_out_pos;
    logic [CNT_W-1:0]        r_out_count, n_out_count;

    t_chain_ctl              w_ctl;
    logic signed [VAL_W-1:0] w_head;
    logic                    w_in_acc;
    logic                    w_is_push;
    logic                    w_full;
    logic                    w_out_free;
    logic [CNT_W-1:0]        w_back_pos;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_is_push  = (i_operation == OP_APPEND) || (i_operation == OP_PREPEND);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_back_pos = r_count - CNT_W'(1) - CNT_W'(r_hit_k);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_key        = r_key;
        n_back       = r_back;
        n_hit        = r_hit;
        n_hit_k      = r_hit_k;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        w_ctl.op       = CH_HOLD;
        w_ctl.load_idx = r_count[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_is_push) begin
                        n_out_valid = 1'b1;
                        n_out_pos   = NOT_FOUND;
                        if (w_full) begin
                            n_out_status = 1'b1;
                            n_out_count  = r_count;
                        end else begin
                            w_ctl.op     = (i_operation == OP_APPEND) ? CH_APPEND : CH_PREPEND;
                            n_count      = r_count + CNT_W'(1);
                            n_out_status = 1'b0;
                            n_out_count  = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_key   = i_value;
                        n_back  = (i_operation == OP_SEARCH_BACK);
                        n_hit   = 1'b0;
                        n_step  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_ctl.op = CH_ROTATE;
                if ((CNT_W'(r_step) < r_count) && (w_head == r_key)) begin
                    if (!r_hit || r_back) begin
                        n_hit   = 1'b1;
                        n_hit_k = r_step;
                    end
                end
                if (r_step == IDX_W'(DEPTH - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = 1'b0;
                    n_out_count  = r_count;
                    if (!r_hit) begin
                        n_out_pos = NOT_FOUND;
                    end else if (r_back) begin
                        n_out_pos = POS_W'(w_back_pos);
                    end else begin
                        n_out_pos = POS_W'(r_hit_k);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_hit       <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_key        <= n_key;
        r_back       <= n_back;
        r_hit_k      <= n_hit_k;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

    bds_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_value (i_value),
        .o_head  (w_head)
    );

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_pos;
    assign o_empty          = (r_out_count == '0);
    assign o_count          = CNTO_W'(r_out_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input open during scan");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_push && w_full) |=> ($stable(r_count) && o_out_valid && o_status))
        else $error("push while full changed state");

    a_reject_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_found_position == NOT_FOUND))
        else $error("rejected push reports a position");
`endif

endmodule

// File: test/tb_bounded_deque_search_top.sv
// testbench for the bounded deque with front and back search, checked against a shadow deque
`timescale 1ns / 1ps

module tb_bounded_deque_search_top;
    import bds_pkg::*;

    typedef struct {
        logic                    status;
        logic signed [POS_W-1:0] found_position;
        logic                    empty;
        logic [CNTO_W-1:0]       count;
    } t_deque_result;

    class deque_shadow;
        logic [VAL_W-1:0] cells [DEPTH];
        int               head;
        int               fill;
        int               failures;
        t_deque_result    pending_results [$];

        function new();
            head     = 0;
            fill     = 0;
            failures = 0;
        endfunction

        function int held();
            return fill;
        endfunction

        function logic [VAL_W-1:0] entry(int k);
            return cells[(head + k) % DEPTH];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void take_word(t_op op, logic [VAL_W-1:0] val);
            t_deque_result r;
            bit            hit;
            int            k;
            int            idx;
            r.status         = 1'b0;
            r.found_position = -1;
            hit              = 1'b0;
            case (op)
                OP_APPEND, OP_PREPEND: begin
                    if (fill >= DEPTH) begin
                        r.status = 1'b1;
                    end else if (op == OP_APPEND) begin
                        cells[(head + fill) % DEPTH] = val;
                        fill++;
                    end else begin
                        head        = (head + DEPTH - 1) % DEPTH;
                        cells[head] = val;
                        fill++;
                    end
                end
                default: begin
                    for (k = 0; k < fill; k++) begin
                        if (op == OP_SEARCH_FRONT)
                            idx = (head + k) % DEPTH;
                        else
                            idx = (head + fill - 1 - k) % DEPTH;
                        if (!hit && cells[idx] == val) begin
                            hit              = 1'b1;
                            r.found_position = k;
                        end
                    end
                end
            endcase
            r.empty = (fill == 0);
            r.count = fill[CNTO_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic status, logic signed [POS_W-1:0] found_position,
                                   logic empty, logic [CNTO_W-1:0] count);
            t_deque_result want;
            if (pending_results.size() == 0) begin
                $error("result word with no expected word waiting");
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status) begin
                $error("status expected %0d got %0d", want.status, status);
                failures++;
            end
            if (found_position !== want.found_position) begin
                $error("found_position expected %0d got %0d",
                       want.found_position, found_position);
                failures++;
            end
            if (empty !== want.empty) begin
                $error("empty expected %0d got %0d", want.empty, empty);
                failures++;
            end
            if (count !== want.count) begin
                $error("count expected %0d got %0d", want.count, count);
                failures++;
            end
        endfunction
    endclass

    localparam logic [VAL_W-1:0] V_MIN = 64'h8000_0000_0000_0000;
    localparam logic [VAL_W-1:0] V_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] V_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] VALUE_POOL [8] = '{
        64'd0, 64'd1, V_ONES, V_MIN, V_MAX,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd5
    };
    localparam int PHASE_WORDS = 650;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [OP_W-1:0]         i_operation;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_status;
    logic signed [POS_W-1:0] o_found_position;
    logic                    o_empty;
    logic [CNTO_W-1:0]       o_count;

    int          in_idle_pct;
    int          out_idle_pct;
    deque_shadow shadow;

    bounded_deque_search_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_empty          (o_empty),
        .o_count          (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            shadow.check_result(o_status, o_found_position, o_empty, o_count);
    end

    task automatic send_word(input t_op op, input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < in_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        shadow.take_word(op, val);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VAL_W-1:0] live_value();
        return shadow.entry($urandom_range(shadow.held() - 1));
    endfunction

    task automatic send_random_word();
        int               sel;
        t_op              op;
        logic [VAL_W-1:0] val;
        sel = $urandom_range(99);
        if ($urandom_range(99) < 8) begin
            op = $urandom_range(1) ? OP_PREPEND : OP_APPEND;
            if (sel < 60 || shadow.held() == 0)
                val = random_value();
            else if (sel < 80)
                val = VALUE_POOL[$urandom_range(7)];
            else
                val = live_value();
        end else begin
            op = $urandom_range(1) ? OP_SEARCH_BACK : OP_SEARCH_FRONT;
            if (shadow.held() == 0 || sel >= 93)
                val = random_value();
            else if (sel < 70)
                val = live_value();
            else if (sel < 85)
                val = VALUE_POOL[$urandom_range(7)];
            else
                val = live_value() ^ (64'd1 << $urandom_range(VAL_W - 1));
        end
        send_word(op, val);
    endtask

    initial begin
        int phase;
        int n;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = OP_APPEND;
        i_value      = '0;
        i_out_stall  = 1'b0;
        in_idle_pct  = 29;
        out_idle_pct = 51;
        shadow       = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // searches of an empty store
        send_word(OP_SEARCH_FRONT, 64'd0);
        send_word(OP_SEARCH_BACK, V_MAX);
        // extremes and duplicates from both ends
        send_word(OP_APPEND, V_MAX);
        send_word(OP_APPEND, V_MIN);
        send_word(OP_PREPEND, 64'd0);
        send_word(OP_PREPEND, V_ONES);
        send_word(OP_APPEND, 64'd5);
        send_word(OP_PREPEND, 64'd5);
        send_word(OP_APPEND, V_MIN);
        send_word(OP_SEARCH_FRONT, 64'd5);
        send_word(OP_SEARCH_BACK, 64'd5);
        send_word(OP_SEARCH_FRONT, V_MIN);
        send_word(OP_SEARCH_BACK, V_MIN);
        send_word(OP_SEARCH_FRONT, V_MAX);
        send_word(OP_SEARCH_BACK, V_MAX);
        send_word(OP_SEARCH_FRONT, V_ONES);
        send_word(OP_SEARCH_BACK, 64'd0);
        send_word(OP_SEARCH_FRONT, 64'd123);
        send_word(OP_SEARCH_BACK, 64'd4);
        send_word(OP_SEARCH_FRONT, V_MIN ^ 64'd1);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct  = 29;
                    out_idle_pct = 51;
                end
                1: begin
                    in_idle_pct  = 51;
                    out_idle_pct = 29;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_WORDS; n++)
                send_random_word();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (shadow.pending() > 0)
            @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (shadow.failures == 0 && shadow.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
